FILE: sv/mdt_pkg.sv
// ---------------------------------------------------------------------------
// mdt_pkg
// Shared constants, codes and helper functions of the terrain generator.
// ---------------------------------------------------------------------------
`default_nettype none

package mdt_pkg;

   localparam int MAX_SIDE = 256;
   localparam int COORD_W  = $clog2(MAX_SIDE);
   localparam int SIDE_W   = COORD_W + 1;
   localparam int ADDR_W   = 2 * COORD_W;
   localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
   localparam int H_W      = 32;
   localparam int LFSR_W   = 16;
   localparam int AMP_W    = 32;

   localparam logic [LFSR_W-1:0] LFSR_MASK     = 16'hB400;
   localparam logic [LFSR_W-1:0] SEED_FALLBACK = 16'd44257;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_GEN   = 2'd2;

   localparam logic [1:0] REG_GRID_SIZE     = 2'd0;
   localparam logic [1:0] REG_HEIGHT_REDUCE = 2'd1;
   localparam logic [1:0] REG_RANDOM_SEED   = 2'd2;

   localparam logic [SIDE_W-1:0] GRID_RESET   = SIDE_W'(MAX_SIDE);
   localparam logic [15:0]       REDUCE_RESET = 16'd32768;
   localparam logic [15:0]       SEED_RESET   = 16'd44257;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [SIDE_W-1:0]  side_type;

   function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
      logic [LFSR_W-1:0] r;
      r = v >> 1;
      if (v[0]) begin
         r = r ^ LFSR_MASK;
      end
      return r;
   endfunction

   function automatic side_type side_clamp(input side_type g);
      side_type r;
      r = g;
      if (g < side_type'(2)) begin
         r = side_type'(2);
      end else if (g > side_type'(MAX_SIDE)) begin
         r = side_type'(MAX_SIDE);
      end
      return r;
   endfunction

   // smallest power of two not below n
   function automatic side_type pow2_ceil(input side_type n);
      side_type r;
      r = side_type'(MAX_SIDE);
      for (int i = SIDE_W - 1; i >= 0; i--) begin
         if ((side_type'(1) << i) >= n) begin
            r = side_type'(1) << i;
         end
      end
      return r;
   endfunction

   // (x+step) mod n, pinned to n-1 when it wraps below x
   function automatic coord_type wrap_next(input coord_type x, input side_type step,
                                           input side_type n);
      logic [SIDE_W:0] v;
      v = {2'b00, x} + {1'b0, step};
      if (v >= {1'b0, n}) begin
         v = v - {1'b0, n};
      end
      if (v >= {1'b0, n}) begin
         v = v - {1'b0, n};
      end
      if (v < {2'b00, x}) begin
         v = {1'b0, n} - 1'b1;
      end
      return v[COORD_W-1:0];
   endfunction

   function automatic coord_type wrap_add(input coord_type x, input side_type d,
                                          input side_type n);
      logic [SIDE_W:0] v;
      v = {2'b00, x} + {1'b0, d};
      if (v >= {1'b0, n}) begin
         v = v - {1'b0, n};
      end
      return v[COORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: sv/mdt_ram.sv
// ---------------------------------------------------------------------------
// mdt_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module mdt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

FILE: sv/midpoint_displacement_terrain.sv
// ---------------------------------------------------------------------------
// midpoint_displacement_terrain
// Square height grid in one RAM with point write/read and a diamond-square
// generate sequencer that reads, averages, displaces and writes back.
//
//   channel   ports                         handshake
//   request   req_cmd/pos_x/pos_y/height_in start & !busy
//   response  rsp_height_out/rsp_gen_done   rsp_valid, one cycle
//   config    csr_index/csr_wdata           csr_we
//
// Point writes land in the cycle of acceptance, reads answer in the cycle after
// acceptance, and both can be issued every cycle while busy is low. A generate
// walks every cell of every pass through address setup, reads one at a time on
// the single RAM read port, draws and writes. After reset a clearing pass zeroes
// all 65536 grid words with busy high. The response side has no stall.
// ---------------------------------------------------------------------------
`default_nettype none

module midpoint_displacement_terrain (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_cmd,
   input  wire logic [7:0]         req_pos_x,
   input  wire logic [7:0]         req_pos_y,
   input  wire logic signed [31:0] req_height_in,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_height_out,
   output logic                    rsp_gen_done,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_ADDR  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_DRAW  = 3'd4;
   localparam logic [2:0] S_WR_A  = 3'd5;
   localparam logic [2:0] S_WR_B  = 3'd6;
   localparam logic [2:0] S_NEXT  = 3'd7;

   localparam int SUM_W = mdt_pkg::H_W + 3;
   localparam int S_W   = mdt_pkg::AMP_W + 1;

   logic [2:0]                   state_ff, state_in;
   logic [mdt_pkg::ADDR_W-1:0]   clr_ff, clr_in;
   mdt_pkg::side_type            grid_ff, grid_in;
   logic [15:0]                  reduce_ff, reduce_in;
   logic [mdt_pkg::LFSR_W-1:0]   lfsr_ff, lfsr_in;
   mdt_pkg::side_type            n_ff, n_in;
   mdt_pkg::side_type            step_ff, step_in;
   logic [mdt_pkg::AMP_W-1:0]    amp_ff, amp_in;
   mdt_pkg::coord_type           wx_ff, wx_in, wy_ff, wy_in;
   logic                         phase_ff, phase_in;
   mdt_pkg::coord_type           nx_ff, ny_ff, mx_ff, my_ff, px_ff, py_ff;
   logic [2:0]                   rdi_ff, rdi_in;
   logic                         cap_ff;
   logic [2:0]                   capi_ff;
   logic signed [SUM_W-1:0]      top_ff, left_ff;
   logic                         drw_ff, drw_in;
   logic [S_W-1:0]               s0_ff, s1_ff;
   logic                         rdpend_ff, done_ff, done_in;

   logic                         accept;
   logic                         ram_we;
   logic [mdt_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
   logic [mdt_pkg::H_W-1:0]      ram_wdata, ram_rdata;
   logic                         issue;
   logic [mdt_pkg::LFSR_W-1:0]   lfsr_adv;
   logic [mdt_pkg::LFSR_W+S_W-1:0] prod;
   logic [mdt_pkg::AMP_W+15:0]   amp_prod;
   logic signed [SUM_W-1:0]      wsum, wq;
   logic [S_W-1:0]               wsel;
   logic signed [SUM_W:0]        wdisp, wval;
   mdt_pkg::side_type            half;
   logic [mdt_pkg::SIDE_W:0]     xn, yn;

   assign accept = start && !busy;
   assign busy   = state_ff != S_IDLE;
   assign half   = step_ff >> 1;
   assign issue  = state_ff == S_READ;

   mdt_ram #(
      .WIDTH(mdt_pkg::H_W),
      .DEPTH(mdt_pkg::DEPTH)
   ) u_grid (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // average plus displacement for the point being written
   always_comb begin
      if (state_ff == S_WR_B) begin
         wsum = left_ff;
         wsel = s0_ff;
      end else begin
         wsum = top_ff;
         wsel = phase_ff ? s1_ff : s0_ff;
      end
      wq = $signed(wsum + (wsum[SUM_W-1] ? SUM_W'(3) : SUM_W'(0))) >>> 2;
      if (phase_ff) begin
         wdisp = $signed({2'b00, wsel}) - $signed({3'b000, amp_ff});
      end else begin
         wdisp = $signed({3'b000, amp_ff}) - $signed({2'b00, wsel});
      end
      wval = {wq[SUM_W-1], wq} + wdisp;
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = {req_pos_y, req_pos_x};
      ram_wdata = req_height_in;
      ram_raddr = {req_pos_y, req_pos_x};
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else if (state_ff == S_IDLE) begin
         ram_we = accept && req_cmd == mdt_pkg::CMD_WRITE;
      end else if (state_ff == S_WR_A || state_ff == S_WR_B) begin
         ram_we    = 1'b1;
         ram_waddr = (state_ff == S_WR_B) ? {my_ff, wx_ff} :
                     (phase_ff ? {wy_ff, mx_ff} : {my_ff, mx_ff});
         if (wval > $signed((SUM_W+1)'(32'sh7FFFFFFF))) begin
            ram_wdata = 32'h7FFFFFFF;
         end else if (wval < -$signed((SUM_W+1)'(33'sh080000000))) begin
            ram_wdata = 32'h80000000;
         end else begin
            ram_wdata = wval[mdt_pkg::H_W-1:0];
         end
      end
      if (issue) begin
         case (rdi_ff)
            3'd0: ram_raddr = {wy_ff, wx_ff};
            3'd1: ram_raddr = phase_ff ? {my_ff, mx_ff} : {wy_ff, nx_ff};
            3'd2: ram_raddr = phase_ff ? {wy_ff, nx_ff} : {ny_ff, wx_ff};
            3'd3: ram_raddr = phase_ff ? {py_ff, mx_ff} : {ny_ff, nx_ff};
            3'd4: ram_raddr = {ny_ff, wx_ff};
            3'd5: ram_raddr = {my_ff, px_ff};
            default: ram_raddr = {wy_ff, wx_ff};
         endcase
      end
   end

   assign lfsr_adv = mdt_pkg::lfsr_next(lfsr_ff);
   assign prod     = lfsr_adv * {amp_ff, 1'b0};
   assign amp_prod = amp_ff * reduce_ff;
   assign xn       = {2'b00, wx_ff} + {1'b0, step_ff};
   assign yn       = {2'b00, wy_ff} + {1'b0, step_ff};

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      grid_in   = grid_ff;
      reduce_in = reduce_ff;
      lfsr_in   = lfsr_ff;
      n_in      = n_ff;
      step_in   = step_ff;
      amp_in    = amp_ff;
      wx_in     = wx_ff;
      wy_in     = wy_ff;
      phase_in  = phase_ff;
      rdi_in    = rdi_ff;
      drw_in    = drw_ff;
      done_in   = 1'b0;
      if (csr_we) begin
         case (csr_index)
            mdt_pkg::REG_GRID_SIZE:     grid_in = csr_wdata[mdt_pkg::SIDE_W-1:0];
            mdt_pkg::REG_HEIGHT_REDUCE: reduce_in = csr_wdata;
            mdt_pkg::REG_RANDOM_SEED:
               lfsr_in = (csr_wdata == '0) ? mdt_pkg::SEED_FALLBACK : csr_wdata;
            default: ;
         endcase
      end
      case (state_ff)
         S_IDLE: begin
            if (accept && req_cmd == mdt_pkg::CMD_GEN) begin
               n_in     = mdt_pkg::side_clamp(grid_ff);
               step_in  = mdt_pkg::pow2_ceil(n_in);
               amp_in   = mdt_pkg::AMP_W'(step_in) << 15;
               wx_in    = '0;
               wy_in    = '0;
               phase_in = 1'b0;
               state_in = S_ADDR;
            end
         end
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_ADDR: begin
            rdi_in   = '0;
            state_in = S_READ;
         end
         S_READ: begin
            rdi_in = rdi_ff + 1'b1;
            if (rdi_ff == (phase_ff ? 3'd5 : 3'd3)) begin
               drw_in   = 1'b0;
               state_in = S_DRAW;
            end
         end
         S_DRAW: begin
            lfsr_in = lfsr_adv;
            drw_in  = 1'b1;
            if (!phase_ff || drw_ff) begin
               state_in = S_WR_A;
            end
         end
         S_WR_A: begin
            state_in = phase_ff ? S_WR_B : S_NEXT;
         end
         S_WR_B: begin
            state_in = S_NEXT;
         end
         S_NEXT: begin
            state_in = S_ADDR;
            if (xn < {1'b0, n_ff}) begin
               wx_in = xn[mdt_pkg::COORD_W-1:0];
            end else begin
               wx_in = '0;
               if (yn < {1'b0, n_ff}) begin
                  wy_in = yn[mdt_pkg::COORD_W-1:0];
               end else begin
                  wy_in = '0;
                  if (!phase_ff) begin
                     phase_in = 1'b1;
                  end else begin
                     phase_in = 1'b0;
                     step_in  = step_ff >> 1;
                     amp_in   = amp_prod[mdt_pkg::AMP_W+15:16];
                     if (step_ff == mdt_pkg::side_type'(1)) begin
                        step_in  = '0;
                        amp_in   = '0;
                        done_in  = 1'b1;
                        state_in = S_IDLE;
                     end
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         grid_ff   <= mdt_pkg::GRID_RESET;
         reduce_ff <= mdt_pkg::REDUCE_RESET;
         lfsr_ff   <= mdt_pkg::SEED_RESET;
         step_ff   <= '0;
         amp_ff    <= '0;
         wx_ff     <= '0;
         wy_ff     <= '0;
         phase_ff  <= 1'b0;
         rdi_ff    <= '0;
         drw_ff    <= 1'b0;
         cap_ff    <= 1'b0;
         rdpend_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         grid_ff   <= grid_in;
         reduce_ff <= reduce_in;
         lfsr_ff   <= lfsr_in;
         step_ff   <= step_in;
         amp_ff    <= amp_in;
         wx_ff     <= wx_in;
         wy_ff     <= wy_in;
         phase_ff  <= phase_in;
         rdi_ff    <= rdi_in;
         drw_ff    <= drw_in;
         cap_ff    <= issue;
         rdpend_ff <= accept && req_cmd == mdt_pkg::CMD_READ;
         done_ff   <= done_in;
      end
   end

   // neighbor coordinates, sums and draws
   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      capi_ff <= rdi_ff;
      if (state_ff == S_ADDR) begin
         nx_ff   <= mdt_pkg::wrap_next(wx_ff, step_ff, n_ff);
         ny_ff   <= mdt_pkg::wrap_next(wy_ff, step_ff, n_ff);
         mx_ff   <= mdt_pkg::wrap_add(wx_ff, half, n_ff);
         my_ff   <= mdt_pkg::wrap_add(wy_ff, half, n_ff);
         px_ff   <= mdt_pkg::wrap_add(wx_ff, n_ff - half, n_ff);
         py_ff   <= mdt_pkg::wrap_add(wy_ff, n_ff - half, n_ff);
         top_ff  <= '0;
         left_ff <= '0;
      end else if (cap_ff) begin
         if (!phase_ff || capi_ff < 3'd4) begin
            top_ff <= top_ff + SUM_W'($signed(ram_rdata));
         end
         if (phase_ff && (capi_ff < 3'd2 || capi_ff > 3'd3)) begin
            left_ff <= left_ff + SUM_W'($signed(ram_rdata));
         end
      end
      if (state_ff == S_DRAW) begin
         if (drw_ff) begin
            s1_ff <= prod[mdt_pkg::LFSR_W+S_W-1:16];
         end else begin
            s0_ff <= prod[mdt_pkg::LFSR_W+S_W-1:16];
         end
      end
   end

   assign rsp_valid      = rdpend_ff || done_ff;
   assign rsp_gen_done   = done_ff;
   assign rsp_height_out = done_ff ? 32'sd0 : $signed(ram_rdata);

`ifndef SYNTHESIS
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == mdt_pkg::CMD_READ |=> rsp_valid && !rsp_gen_done)
      else $error("read word not answered");
   a_gen_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == mdt_pkg::CMD_GEN |=> busy)
      else $error("generate did not raise busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_gen_done |-> !busy && $past(state_ff) == S_NEXT)
      else $error("done pulse outside end of generate");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid)
      else $error("response during clearing pass");
`endif

endmodule

`default_nettype wire

FILE: tb/midpoint_displacement_terrain_test.sv
// ---------------------------------------------------------------------------
// midpoint_displacement_terrain_test
// Self-checking bench for the terrain generator: point writes, reads and
// diamond-square generate commands are driven in directed and random runs, mirrored in a local
// height map, and every response word is checked against it in order.
// ---------------------------------------------------------------------------
`default_nettype none

module midpoint_displacement_terrain_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 300000;
   localparam int PHASES         = 8;
   localparam int PHASE_WORDS    = 185;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   typedef struct {
      logic [1:0]         cmd;
      logic [7:0]         x;
      logic [7:0]         y;
      logic signed [31:0] h;
   } cmd_word_type;

   typedef struct {
      logic signed [31:0] height;
      logic               done;
   } rsp_word_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [1:0]         req_cmd = mdt_pkg::CMD_WRITE;
   logic [7:0]         req_pos_x = '0;
   logic [7:0]         req_pos_y = '0;
   logic signed [31:0] req_height_in = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_height_out;
   logic               rsp_gen_done;
   logic               csr_we = 0;
   logic [1:0]         csr_index = mdt_pkg::REG_GRID_SIZE;
   logic [15:0]        csr_wdata = '0;

   midpoint_displacement_terrain DUT (.*);

   always #5 clock = ~clock;

   // local copy of the block state
   logic signed [31:0] height_map [mdt_pkg::DEPTH];
   logic [8:0]         side_reg = 9'd256;
   logic [15:0]        reduce_reg = mdt_pkg::REDUCE_RESET;
   logic [15:0]        lfsr_state = mdt_pkg::SEED_RESET;

   cmd_word_type pending_words[$];
   rsp_word_type expected_words[$];
   cmd_word_type cur;
   int        idle_pct = 25;
   int        errors = 0;
   int        words_sent = 0, words_checked = 0, gens_done = 0;
   int        stall_count = 0;

   function automatic logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint draw_offset(logic [31:0] amp);
      logic lsb;
      longint unsigned prod;
      lsb = lfsr_state[0];
      lfsr_state = lfsr_state >> 1;
      if (lsb) lfsr_state = lfsr_state ^ 16'hB400;
      prod = (longint'(lfsr_state) * (longint'(amp) * 2)) >> 16;
      return longint'(prod);
   endfunction

   function automatic longint hm(int x, int y);
      return longint'(height_map[y * mdt_pkg::MAX_SIDE + x]);
   endfunction

   function automatic longint avg4(longint a, longint b, longint c, longint d);
      return (a + b + c + d) / 4;
   endfunction

   function automatic void refine_pass(int n, int step, logic [31:0] amp, bit square);
      int h, nx, ny, mx, my, px, py;
      longint tl, tr, ctr, up, bl, lf, left_v, top_v, s;
      h = step / 2;
      for (int y = 0; y < n; y += step) begin
         for (int x = 0; x < n; x += step) begin
            nx = (x + step) % n;
            ny = (y + step) % n;
            mx = (x + h) % n;
            my = (y + h) % n;
            if (nx < x) nx = n - 1;
            if (ny < y) ny = n - 1;
            if (!square) begin
               s = draw_offset(amp);
               height_map[my * mdt_pkg::MAX_SIDE + mx] =
                  sat32(avg4(hm(x, y), hm(nx, y), hm(x, ny), hm(nx, ny)) +
                        (longint'(amp) - s));
            end else begin
               px = (x + n - h) % n;
               py = (y + n - h) % n;
               tl = hm(x, y); tr = hm(nx, y); ctr = hm(mx, my);
               up = hm(mx, py); bl = hm(x, ny); lf = hm(px, my);
               left_v = avg4(tl, ctr, bl, lf) + (draw_offset(amp) - longint'(amp));
               top_v = avg4(tl, ctr, tr, up) + (draw_offset(amp) - longint'(amp));
               height_map[y * mdt_pkg::MAX_SIDE + mx] = sat32(top_v);
               height_map[my * mdt_pkg::MAX_SIDE + x] = sat32(left_v);
            end
         end
      end
   endfunction

   function automatic int side_used();
      if (side_reg < 2) return 2;
      if (side_reg > mdt_pkg::MAX_SIDE) return mdt_pkg::MAX_SIDE;
      return side_reg;
   endfunction

   function automatic void generate_terrain();
      int n, step;
      logic [31:0] amp;
      n = side_used();
      step = 1;
      while (step < n) step *= 2;
      amp = 32'(step) << 15;
      while (step > 0) begin
         refine_pass(n, step, amp, 0);
         refine_pass(n, step, amp, 1);
         step /= 2;
         amp = 32'((longint'(amp) * longint'(reduce_reg)) >> 16);
      end
   endfunction

   function automatic void apply_word(cmd_word_type w);
      rsp_word_type e;
      case (w.cmd)
         mdt_pkg::CMD_WRITE:
            height_map[int'(w.y) * mdt_pkg::MAX_SIDE + int'(w.x)] = w.h;
         mdt_pkg::CMD_READ: begin
            e.height = height_map[int'(w.y) * mdt_pkg::MAX_SIDE + int'(w.x)];
            e.done = 0;
            expected_words.push_back(e);
         end
         mdt_pkg::CMD_GEN: begin
            generate_terrain();
            e.height = 0;
            e.done = 1;
            expected_words.push_back(e);
         end
         default: ;
      endcase
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
      end else begin
         if (start && !busy) begin
            apply_word(cur);
            words_sent++;
         end
         if (!start || !busy) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
               cur = pending_words.pop_front();
               req_cmd <= cur.cmd;
               req_pos_x <= cur.x;
               req_pos_y <= cur.y;
               req_height_in <= cur.h;
               start <= 1;
            end else begin
               start <= 0;
            end
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               report("unexpected word", rsp_height_out, 32'd0);
            end else begin
               e = expected_words.pop_front();
               if (rsp_height_out !== e.height) report("height_out", rsp_height_out, e.height);
               if (rsp_gen_done !== e.done)
                  report("gen_done", 32'(rsp_gen_done), 32'(e.done));
               words_checked++;
               if (e.done) gens_done++;
            end
         end
         if ((start && !busy) || rsp_valid) begin
            stall_count <= 0;
         end else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("[midpoint_displacement_terrain] ERROR");
            $finish;
         end else begin
            stall_count <= stall_count + 1;
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [15:0] v);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         mdt_pkg::REG_GRID_SIZE: side_reg = v[8:0];
         mdt_pkg::REG_HEIGHT_REDUCE: reduce_reg = v;
         mdt_pkg::REG_RANDOM_SEED: lfsr_state = (v == 0) ? mdt_pkg::SEED_FALLBACK : v;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic wait_idle();
      while (pending_words.size() != 0 || expected_words.size() != 0 || start || busy)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic push(logic [1:0] c, logic [7:0] x, logic [7:0] y, logic [31:0] h);
      cmd_word_type w;
      w.cmd = c; w.x = x; w.y = y; w.h = h;
      pending_words.push_back(w);
   endtask

   function automatic logic [7:0] pick_coord();
      return ($urandom_range(99) < 70) ? 8'($urandom_range(0, 15)) : 8'($urandom);
   endfunction

   function automatic logic [31:0] pick_height();
      case ($urandom_range(9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($urandom_range(0, 65535)) << 8;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int gside, sel;
      bit gen_ok;
      foreach (height_map[i]) height_map[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // directed: corners, extremes, unknown command, saturation in a generate
      csr_write(mdt_pkg::REG_GRID_SIZE, 16'd4);
      csr_write(mdt_pkg::REG_HEIGHT_REDUCE, 16'd0);
      csr_write(mdt_pkg::REG_RANDOM_SEED, 16'd0);
      push(mdt_pkg::CMD_READ, 8'd0, 8'd0, 0);
      push(mdt_pkg::CMD_WRITE, 8'd255, 8'd255, 32'h7fffffff);
      push(mdt_pkg::CMD_WRITE, 8'd0, 8'd0, 32'h7fffffff);
      push(mdt_pkg::CMD_WRITE, 8'd3, 8'd0, 32'h7fffffff);
      push(mdt_pkg::CMD_WRITE, 8'd0, 8'd3, 32'h7fffffff);
      push(mdt_pkg::CMD_WRITE, 8'd3, 8'd3, 32'h80000000);
      push(mdt_pkg::CMD_READ, 8'd255, 8'd255, 0);
      push(CMD_UNKNOWN, 8'd1, 8'd1, 32'hffffffff);
      push(mdt_pkg::CMD_GEN, 8'd0, 8'd0, 0);
      for (int y = 0; y < 4; y++)
         for (int x = 0; x < 4; x++) push(mdt_pkg::CMD_READ, 8'(x), 8'(y), 0);
      push(mdt_pkg::CMD_READ, 8'd200, 8'd17, 0);
      wait_idle();
      csr_write(mdt_pkg::REG_GRID_SIZE, 16'd1);
      csr_write(mdt_pkg::REG_HEIGHT_REDUCE, 16'hffff);
      csr_write(mdt_pkg::REG_RANDOM_SEED, 16'hffff);
      push(mdt_pkg::CMD_GEN, 8'd0, 8'd0, 0);
      push(mdt_pkg::CMD_READ, 8'd1, 8'd1, 0);
      push(mdt_pkg::CMD_READ, 8'd0, 8'd1, 0);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         idle_pct = (p < 3) ? 25 : (p < 6) ? 58 : 0;
         sel = $urandom_range(9);
         gside = (p == 1) ? 511 : (p == 4) ? 256 : (p == 6) ? 0 :
                 (sel == 0) ? 33 : $urandom_range(2, 17);
         csr_write(mdt_pkg::REG_GRID_SIZE, 16'(gside));
         csr_write(mdt_pkg::REG_HEIGHT_REDUCE,
                   (p == 2) ? 16'd0 : (p == 5) ? 16'hffff : 16'($urandom));
         csr_write(mdt_pkg::REG_RANDOM_SEED, (p == 3) ? 16'd1 : 16'($urandom));
         gen_ok = side_used() <= 40;
         for (int i = 0; i < PHASE_WORDS; i++) begin
            sel = $urandom_range(99);
            if (sel < 40)
               push(mdt_pkg::CMD_WRITE, pick_coord(), pick_coord(), pick_height());
            else if (sel < 93)
               push(mdt_pkg::CMD_READ, pick_coord(), pick_coord(), $urandom);
            else if (sel < 97 && gen_ok)
               push(mdt_pkg::CMD_GEN, 8'($urandom), 8'($urandom), $urandom);
            else
               push(CMD_UNKNOWN, 8'($urandom), 8'($urandom), $urandom);
         end
         // hold the sender off until every response has come back
         wait_idle();
      end

      repeat (50) @(posedge clock);
      $display("covered %0d command words, %0d responses checked, %0d generates",
               words_sent, words_checked, gens_done);
      $display("grid sides 2..33 plus clamped 0/1/511, reduce and seed extremes, three pacings");
      if (errors == 0 && expected_words.size() == 0) begin
         $display("[midpoint_displacement_terrain] OK");
      end else begin
         $display("[midpoint_displacement_terrain] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
